[design/tiled_texel_decoder_defines.svh]
// assertion helpers shared by the decoder modules
`ifndef TILED_TEXEL_DECODER_DEFINES_SVH
`define TILED_TEXEL_DECODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TTD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TTD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ttd_pkg.sv]
package ttd_pkg;

    localparam int MAX_DIM_DEF     = 1024;
    localparam int PAL_ENTRIES_DEF = 256;
    // internal coordinate width, covers block column times tile width at the largest size
    localparam int CW              = 14;
    localparam int QDEPTH          = 4;

    // texture format codes
    localparam logic [3:0] FMT_I4     = 4'd0;
    localparam logic [3:0] FMT_I8     = 4'd1;
    localparam logic [3:0] FMT_IA4    = 4'd2;
    localparam logic [3:0] FMT_IA8    = 4'd3;
    localparam logic [3:0] FMT_RGB565 = 4'd4;
    localparam logic [3:0] FMT_RGB5A3 = 4'd5;
    localparam logic [3:0] FMT_RGBA8  = 4'd6;
    localparam logic [3:0] FMT_CI4    = 4'd8;
    localparam logic [3:0] FMT_CI8    = 4'd9;
    localparam logic [3:0] FMT_C14X2  = 4'd10;
    localparam logic [3:0] FMT_CMPR   = 4'd14;

    // palette entry encodings
    localparam logic [1:0] PAL_IA8    = 2'd0;
    localparam logic [1:0] PAL_RGB565 = 2'd1;

    // configuration register indexes
    localparam logic [1:0] REG_FORMAT  = 2'd0;
    localparam logic [1:0] REG_WIDTH   = 2'd1;
    localparam logic [1:0] REG_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_PAL_FMT = 2'd3;

    // item operations
    localparam logic OP_TEXEL   = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    typedef struct packed {
        logic        op;
        logic        first;
        logic [7:0]  tex_byte;
        logic [7:0]  pal_index;
        logic [15:0] pal_value;
    } t_in_item;

    typedef struct packed {
        logic [9:0] pix_x;
        logic [9:0] pix_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_of_run;
    } t_out_pix;

    typedef enum logic [1:0] {
        JOB_PAL_WR = 2'd0,
        JOB_DIRECT = 2'd1,
        JOB_LOOKUP = 2'd2,
        JOB_CMPR   = 2'd3
    } t_job_kind;

    // one queued job: a palette write, or the visible pixels of one byte
    typedef struct packed {
        t_job_kind       kind;
        logic [CW-1:0]   x;
        logic [CW-1:0]   y;
        logic [3:0]      mask;
        logic [31:0]     col0;
        logic [31:0]     col1;
        logic [7:0]      idx0;
        logic [7:0]      idx1;
        logic            gt;
    } t_job;

    // v*255/31 by reciprocal multiply
    function automatic logic [7:0] exp5(input logic [4:0] v);
        logic [31:0] t;
        t = 32'(v) * 32'd255 * 32'd8457;
        return t[25:18];
    endfunction

    // v*255/63
    function automatic logic [7:0] exp6(input logic [5:0] v);
        logic [31:0] t;
        t = 32'(v) * 32'd255 * 32'd16645;
        return t[27:20];
    endfunction

    // v*255/15 is v*17
    function automatic logic [7:0] exp4(input logic [3:0] v);
        return {v, v};
    endfunction

    // v*255/7
    function automatic logic [7:0] exp3(input logic [2:0] v);
        logic [31:0] t;
        t = 32'(v) * 32'd255 * 32'd9363;
        return t[23:16];
    endfunction

    // n/3 for n below 766
    function automatic logic [7:0] div3(input logic [9:0] n);
        logic [31:0] t;
        t = 32'(n) * 32'd21846;
        return t[23:16];
    endfunction

    function automatic logic [31:0] grey(input logic [7:0] v, input logic [7:0] a);
        return {v, v, v, a};
    endfunction

    function automatic logic [31:0] dec565(input logic [15:0] v);
        return {exp5(v[15:11]), exp6(v[10:5]), exp5(v[4:0]), 8'hFF};
    endfunction

    function automatic logic [31:0] dec5a3(input logic [15:0] v);
        logic [31:0] c;
        if ((v & 16'h8000) != 16'h0) begin
            c = {exp5(v[14:10]), exp5(v[9:5]), exp5(v[4:0]), 8'hFF};
        end else begin
            c = {exp4(v[11:8]), exp4(v[7:4]), exp4(v[3:0]), exp3(v[14:12])};
        end
        return c;
    endfunction

endpackage

[design/tiled_texel_decoder.sv]
// tiled texel decoder: texture bytes go in one per transfer in stored tile order
// (big-endian 16-bit texels, rgba8 tiles as an ar half then a gb half, cmpr as four
// 4x4 sub-blocks) and rgba8 pixels with x,y come out, one per transfer; the block
// keeps its own tile position, restarted by the first flag, and pixels outside the
// image are dropped. palette loads pass through the same input channel and are
// applied in order with the pixels. an input byte is taken every cycle while the
// four-entry job queue has room; each byte yields zero to four pixels and the
// output side moves one pixel per cycle while the receiver is ready; cmpr colour
// bytes give up to four pixels, i4/ci4 up to two and the other formats one. a
// byte's pixels pass the job queue, the stage register and the output register.
// the palette ram reads one entry per cycle while pixels issue; unwritten palette
// entries read as the grey ramp through per-entry valid bits: no clearing pass
module tiled_texel_decoder #(
    parameter int MAX_DIM         = ttd_pkg::MAX_DIM_DEF,
    parameter int PALETTE_ENTRIES = ttd_pkg::PAL_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [10:0]       i_cfg_data,
    // input item channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ttd_pkg::t_in_item i_in_item,
    // pixel channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ttd_pkg::t_out_pix o_out_pix
);
    import ttd_pkg::*;

    // front to queue
    logic job_valid, job_ready, job_push;
    t_job job;
    // queue to back
    logic head_valid, head_pop;
    t_job head;

    // front: config registers, tile walk, byte decode into pixel jobs
    ttd_front #(
        .MAX_DIM         (MAX_DIM),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    // a job is queued only when the byte actually makes pixels or a palette write
    assign job_push = job_valid && job_ready;

    // decouples the byte rate from the pixel rate
    ttd_fifo #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job),
        .o_ready (job_ready),
        .i_pop   (head_pop),
        .o_valid (head_valid),
        .o_head  (head)
    );

    // back: palette store, per-pixel issue, colour resolve, output register
    ttd_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (head_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_pix    (o_out_pix)
    );

endmodule

[design/ttd_ram.sv]
module ttd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/ttd_front.sv]
module ttd_front #(
    parameter int MAX_DIM         = 1024,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [10:0]     i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ttd_pkg::t_in_item i_in_item,
    output logic            o_job_valid,
    input  logic            i_job_ready,
    output ttd_pkg::t_job   o_job
);
    import ttd_pkg::*;

    localparam int BCW = $clog2(MAX_DIM / 4) + 1;
    localparam int EW  = ($clog2(MAX_DIM) + 1 > 11) ? $clog2(MAX_DIM) + 1 : 11;

    logic [3:0]     r_fmt;
    logic [10:0]    r_width;
    logic [10:0]    r_height;
    logic [1:0]     r_pal_fmt;
    logic [BCW-1:0] r_col, n_col;
    logic [BCW-1:0] r_row, n_row;
    logic [5:0]     r_bib, n_bib;
    logic [7:0]     r_held, n_held;
    logic [15:0]    r_ez, n_ez;
    logic [15:0]    r_eo, n_eo;
    logic [23:0]    r_ez_rgb, n_ez_rgb;
    logic [23:0]    r_eo_rgb, n_eo_rgb;
    logic [15:0]    r_arbuf [16];

    logic           acc;
    logic           known, tw8, th8, tb64, produce, ar_we;
    logic [3:0]     ar_idx;
    logic [EW-1:0]  eff_w, eff_h, across, down, ar_raw, dn_raw;
    logic [5:0]     b, b_start;
    logic [6:0]     b_next;
    logic [BCW-1:0] col_cur, row_cur;
    logic [7:0]     tb;
    logic [CW-1:0]  bx, by, x, y, ew, eh;
    logic [3:0]     ii;
    logic [15:0]    v16;
    logic [31:0]    ep565;
    logic [15:0]    arv;
    t_job           job;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = i_job_ready;
    assign acc         = i_in_valid && i_job_ready;
    assign tb          = i_in_item.tex_byte;
    assign v16         = {r_held, tb};
    assign ep565       = dec565(v16);

    always_comb begin
        eff_w  = (EW'(r_width) > EW'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(r_width);
        eff_h  = (EW'(r_height) > EW'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(r_height);
        ew     = CW'(eff_w);
        eh     = CW'(eff_h);
        known  = 1'b1;
        tw8    = 1'b0;
        th8    = 1'b0;
        tb64   = 1'b0;
        unique case (r_fmt)
            FMT_I4, FMT_CI4, FMT_CMPR: begin
                tw8 = 1'b1;
                th8 = 1'b1;
            end
            FMT_I8, FMT_IA4, FMT_CI8, FMT_C14X2: begin
                tw8 = 1'b1;
            end
            FMT_IA8, FMT_RGB565, FMT_RGB5A3: begin
                tw8 = 1'b0;
            end
            FMT_RGBA8: begin
                tb64 = 1'b1;
            end
            default: begin
                known = 1'b0;
            end
        endcase
        ar_raw = tw8 ? ((eff_w + EW'(7)) >> 3) : ((eff_w + EW'(3)) >> 2);
        dn_raw = th8 ? ((eff_h + EW'(7)) >> 3) : ((eff_h + EW'(3)) >> 2);
        across = (ar_raw == '0) ? EW'(1) : ar_raw;
        down   = (dn_raw == '0) ? EW'(1) : dn_raw;
        b_start = i_in_item.first ? 6'd0 : r_bib;
        col_cur = i_in_item.first ? '0 : r_col;
        row_cur = i_in_item.first ? '0 : r_row;
        b       = (!tb64 && b_start >= 6'd32) ? 6'd31 : b_start;
        bx = tw8 ? (CW'(col_cur) << 3) : (CW'(col_cur) << 2);
        by = th8 ? (CW'(row_cur) << 3) : (CW'(row_cur) << 2);
        ii  = b[4:1];
        arv = r_arbuf[ii];
    end

    // decode one byte
    always_comb begin
        n_held   = r_held;
        n_ez     = r_ez;
        n_eo     = r_eo;
        n_ez_rgb = r_ez_rgb;
        n_eo_rgb = r_eo_rgb;
        ar_we    = 1'b0;
        ar_idx   = ii;
        produce  = 1'b0;
        x        = bx;
        y        = by;
        job      = '0;
        job.kind = JOB_DIRECT;
        if (i_in_item.op == OP_PALETTE) begin
            job.kind = JOB_PAL_WR;
            job.idx0 = i_in_item.pal_index;
            if (r_pal_fmt == PAL_IA8) begin
                job.col0 = grey(i_in_item.pal_value[15:8], i_in_item.pal_value[7:0]);
            end else if (r_pal_fmt == PAL_RGB565) begin
                job.col0 = dec565(i_in_item.pal_value);
            end else begin
                job.col0 = dec5a3(i_in_item.pal_value);
            end
            produce = ({1'b0, i_in_item.pal_index} < 9'(PALETTE_ENTRIES));
        end else begin
            unique case (r_fmt)
                FMT_I4, FMT_CI4: begin
                    x = bx + CW'({b[1:0], 1'b0});
                    y = by + CW'(b[5:2]);
                    produce = 1'b1;
                    job.kind = (r_fmt == FMT_I4) ? JOB_DIRECT : JOB_LOOKUP;
                    job.col0 = grey(exp4(tb[7:4]), 8'hFF);
                    job.col1 = grey(exp4(tb[3:0]), 8'hFF);
                    job.idx0 = {4'h0, tb[7:4]};
                    job.idx1 = {4'h0, tb[3:0]};
                    job.mask = {2'b00, (x + CW'(1)) < ew && y < eh, x < ew && y < eh};
                end
                FMT_I8, FMT_IA4, FMT_CI8, FMT_C14X2: begin
                    x = bx + CW'(b[2:0]);
                    y = by + CW'(b[5:3]);
                    produce = 1'b1;
                    job.kind = (r_fmt == FMT_I8 || r_fmt == FMT_IA4) ? JOB_DIRECT : JOB_LOOKUP;
                    job.col0 = (r_fmt == FMT_I8) ? grey(tb, 8'hFF)
                                                 : grey(exp4(tb[3:0]), exp4(tb[7:4]));
                    job.idx0 = tb;
                    job.mask = {3'b000, x < ew && y < eh};
                end
                FMT_IA8, FMT_RGB565, FMT_RGB5A3: begin
                    x = bx + CW'(ii[1:0]);
                    y = by + CW'(ii[3:2]);
                    if (!b[0]) begin
                        n_held = tb;
                    end else begin
                        produce = 1'b1;
                        if (r_fmt == FMT_IA8) begin
                            job.col0 = grey(tb, r_held);
                        end else if (r_fmt == FMT_RGB565) begin
                            job.col0 = dec565(v16);
                        end else begin
                            job.col0 = dec5a3(v16);
                        end
                        job.mask = {3'b000, x < ew && y < eh};
                    end
                end
                FMT_RGBA8: begin
                    x = bx + CW'(ii[1:0]);
                    y = by + CW'(ii[3:2]);
                    if (!b[0]) begin
                        n_held = tb;
                    end else if (!b[5]) begin
                        ar_we = 1'b1;
                    end else begin
                        produce = 1'b1;
                        job.col0 = {arv[7:0], r_held, tb, arv[15:8]};
                        job.mask = {3'b000, x < ew && y < eh};
                    end
                end
                FMT_CMPR: begin
                    x = bx + CW'({b[3], 2'b00});
                    y = by + CW'({b[4], 2'b00}) + CW'(b[1:0]);
                    unique case (b[2:0])
                        3'd0, 3'd2: n_held = tb;
                        3'd1: begin
                            n_ez     = v16;
                            n_ez_rgb = ep565[31:8];
                        end
                        3'd3: begin
                            n_eo     = v16;
                            n_eo_rgb = ep565[31:8];
                        end
                        default: begin
                            produce   = 1'b1;
                            job.kind  = JOB_CMPR;
                            job.col0  = {r_ez_rgb, 8'hFF};
                            job.col1  = {r_eo_rgb, 8'hFF};
                            job.idx0  = tb;
                            job.gt    = r_ez > r_eo;
                            job.mask  = {(x + CW'(3)) < ew && y < eh,
                                         (x + CW'(2)) < ew && y < eh,
                                         (x + CW'(1)) < ew && y < eh,
                                         x < ew && y < eh};
                        end
                    endcase
                end
                default: begin
                    produce = 1'b0;
                end
            endcase
            // jobs whose pixels all fall outside the image are not queued
            if (job.mask == 4'h0) begin
                produce = 1'b0;
            end
        end
        job.x = x;
        job.y = y;
    end

    // tile walk
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_bib  = r_bib;
        b_next = {1'b0, b} + 7'd1;
        if (i_in_item.op == OP_TEXEL && known) begin
            n_col = col_cur;
            n_row = row_cur;
            if (b_next >= (tb64 ? 7'd64 : 7'd32)) begin
                n_bib = 6'd0;
                if (EW'(col_cur) + EW'(1) >= across) begin
                    n_col = '0;
                    n_row = (EW'(row_cur) + EW'(1) >= down) ? '0 : row_cur + BCW'(1);
                end else begin
                    n_col = col_cur + BCW'(1);
                end
            end else begin
                n_bib = b_next[5:0];
            end
        end
    end

    assign o_job_valid = i_in_valid && produce;
    assign o_job       = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= FMT_I4;
            r_width   <= 11'd8;
            r_height  <= 11'd8;
            r_pal_fmt <= PAL_IA8;
            r_col     <= '0;
            r_row     <= '0;
            r_bib     <= '0;
            r_held    <= '0;
            r_ez      <= '0;
            r_eo      <= '0;
            r_ez_rgb  <= '0;
            r_eo_rgb  <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_FORMAT:  r_fmt     <= i_cfg_data[3:0];
                    REG_WIDTH:   r_width   <= i_cfg_data;
                    REG_HEIGHT:  r_height  <= i_cfg_data;
                    REG_PAL_FMT: r_pal_fmt <= i_cfg_data[1:0];
                    default:     r_fmt     <= r_fmt;
                endcase
            end
            if (acc) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_bib    <= n_bib;
                r_held   <= n_held;
                r_ez     <= n_ez;
                r_eo     <= n_eo;
                r_ez_rgb <= n_ez_rgb;
                r_eo_rgb <= n_eo_rgb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && ar_we) begin
            r_arbuf[ar_idx] <= v16;
        end
    end

endmodule

[design/ttd_fifo.sv]
`include "tiled_texel_decoder_defines.svh"

module ttd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttd_pkg::t_job i_data,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output ttd_pkg::t_job o_head
);
    import ttd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    assign o_ready = r_cnt != (AW + 1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_cnt <= r_cnt + (AW + 1)'(i_push) - (AW + 1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `TTD_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= (AW + 1)'(DEPTH), "queue count over depth")
    `TTD_ASSERT_NOW(a_pop_nonempty, i_pop, r_cnt != '0, "pop from empty queue")

endmodule

[design/ttd_back.sv]
`include "tiled_texel_decoder_defines.svh"

module ttd_back #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  ttd_pkg::t_job     i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ttd_pkg::t_out_pix o_out_pix
);
    import ttd_pkg::*;

    localparam int PIW = $clog2(PALETTE_ENTRIES);

    typedef struct packed {
        t_job_kind     kind;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [31:0]   col;
        logic [23:0]   ca;
        logic [23:0]   cb;
        logic          gt;
        logic [1:0]    sel;
        logic [7:0]    idx;
        logic          in_range;
        logic          pv;
        logic          last;
    } t_stage;

    logic [3:0]  r_used;
    logic [PALETTE_ENTRIES-1:0] r_pvalid;
    logic        r_s2v;
    t_stage      r_s2, s2_next;
    logic        r_ov;
    t_out_pix    r_out, out_next;

    logic [3:0]  rem, onehot;
    logic [1:0]  j;
    logic        last_px, is_wr, issue, out_adv, s2_free;
    logic [7:0]  lidx;
    logic [31:0] rdata, colour;
    logic [7:0]  p [3];
    logic [7:0]  q [3];
    logic [7:0]  mix [3];

    assign out_adv = !r_ov || i_out_ready;
    assign s2_free = !r_s2v || out_adv;

    always_comb begin
        rem = i_head.mask & ~r_used;
        priority if (rem[0]) j = 2'd0;
        else if (rem[1])     j = 2'd1;
        else if (rem[2])     j = 2'd2;
        else                 j = 2'd3;
        onehot  = 4'b0001 << j;
        last_px = (rem & ~onehot) == 4'h0;
        is_wr   = i_head_valid && i_head.kind == JOB_PAL_WR;
        issue   = i_head_valid && i_head.kind != JOB_PAL_WR && s2_free;
        o_pop   = is_wr || (issue && last_px);
        lidx    = j[0] ? i_head.idx1 : i_head.idx0;
    end

    ttd_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_ENTRIES)
    ) u_pal (
        .i_clk   (i_clk),
        .i_we    (is_wr),
        .i_waddr (i_head.idx0[PIW-1:0]),
        .i_wdata (i_head.col0),
        .i_re    (issue),
        .i_raddr (lidx[PIW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        s2_next          = '0;
        s2_next.kind     = i_head.kind;
        s2_next.x        = i_head.x + CW'(j);
        s2_next.y        = i_head.y;
        s2_next.col      = j[0] ? i_head.col1 : i_head.col0;
        s2_next.ca       = i_head.col0[31:8];
        s2_next.cb       = i_head.col1[31:8];
        s2_next.gt       = i_head.gt;
        s2_next.sel      = i_head.idx0[3'(3'd6 - {j, 1'b0}) +: 2];
        s2_next.idx      = lidx;
        s2_next.in_range = {1'b0, lidx} < 9'(PALETTE_ENTRIES);
        s2_next.pv       = r_pvalid[lidx[PIW-1:0]];
        s2_next.last     = last_px;
    end

    // colour of the staged pixel: cmpr mix, palette lookup or direct colour
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            p[c] = r_s2.ca[8 * (2 - c) +: 8];
            q[c] = r_s2.cb[8 * (2 - c) +: 8];
            if (r_s2.gt) begin
                mix[c] = (r_s2.sel == 2'd2) ? div3({1'b0, p[c], 1'b0} + 10'(q[c]))
                                            : div3(10'(p[c]) + {1'b0, q[c], 1'b0});
            end else begin
                mix[c] = 8'((9'(p[c]) + 9'(q[c])) >> 1);
            end
        end
        unique case (r_s2.kind)
            JOB_LOOKUP: begin
                if (!r_s2.in_range) begin
                    colour = 32'h0;
                end else if (r_s2.pv) begin
                    colour = rdata;
                end else begin
                    colour = grey(r_s2.idx, 8'hFF);
                end
            end
            JOB_CMPR: begin
                if (r_s2.sel == 2'd0) begin
                    colour = {r_s2.ca, 8'hFF};
                end else if (r_s2.sel == 2'd1) begin
                    colour = {r_s2.cb, 8'hFF};
                end else if (!r_s2.gt && r_s2.sel == 2'd3) begin
                    colour = 32'h0;
                end else begin
                    colour = {mix[0], mix[1], mix[2], 8'hFF};
                end
            end
            JOB_DIRECT, JOB_PAL_WR: colour = r_s2.col;
            default: colour = r_s2.col;
        endcase
        out_next.pix_x       = r_s2.x[9:0];
        out_next.pix_y       = r_s2.y[9:0];
        out_next.red         = colour[31:24];
        out_next.green       = colour[23:16];
        out_next.blue        = colour[15:8];
        out_next.alpha       = colour[7:0];
        out_next.last_of_run = r_s2.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_pvalid <= '0;
            r_s2v    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_used <= '0;
            end else if (issue) begin
                r_used <= r_used | onehot;
            end
            if (is_wr) begin
                r_pvalid[i_head.idx0[PIW-1:0]] <= 1'b1;
            end
            if (s2_free) begin
                r_s2v <= issue;
            end
            if (out_adv) begin
                r_ov <= r_s2v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s2 <= s2_next;
        end
        if (out_adv && r_s2v) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_pix   = r_out;

    `TTD_ASSERT_NOW(a_used_in_mask, i_head_valid, (r_used & ~i_head.mask) == 4'h0,
        "consumed pixel outside job mask")
    `TTD_ASSERT_NXT(a_pop_clears, o_pop, r_used == 4'h0, "pixel tally not cleared on pop")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import ttd_pkg::*;

    // palette encodings the package leaves unnamed
    localparam logic [1:0] PAL_RGB5A3     = 2'd2;
    localparam logic [1:0] PAL_RGB5A3_ALT = 2'd3;
    localparam int         CYCLE_LIMIT    = 400000;
    localparam int         DRAIN_CYCLES   = 24;
    localparam int         RANDOM_ITEMS   = 130;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    t_in_item    in_item = '0;
    logic        out_ready = 1'b0;
    logic        o_cfg_ready, o_in_ready, o_out_valid;
    t_out_pix    o_out_pix;

    tiled_texel_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_pix   (o_out_pix)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // decoder copy: registers, tile walk and stores
    // ---------------------------------------------------------------
    logic [3:0]  cur_fmt = FMT_I4;
    logic [10:0] cur_width = 11'd8;
    logic [10:0] cur_height = 11'd8;
    logic [1:0]  cur_pal_fmt = PAL_IA8;

    int unsigned walk_col = 0, walk_row = 0, walk_byte = 0;
    logic [7:0]  held = '0;
    logic [15:0] ar_half [16];
    logic [15:0] ep0 = '0, ep1 = '0;
    logic [31:0] palette [256];

    t_out_pix pix_expected [$];
    t_out_pix run_pix [$];
    t_in_item pending [$];

    int mismatches = 0;
    int items_taken = 0;

    initial begin
        for (int i = 0; i < 256; i++) begin
            palette[i] = {i[7:0], i[7:0], i[7:0], 8'hFF};
        end
        for (int i = 0; i < 16; i++) begin
            ar_half[i] = '0;
        end
    end

    function automatic logic [7:0] scale(int unsigned v, int unsigned top);
        return 8'(v * 255 / top);
    endfunction

    function automatic logic [31:0] rgb565(logic [15:0] v);
        return {scale(v[15:11], 31), scale(v[10:5], 63), scale(v[4:0], 31), 8'hFF};
    endfunction

    function automatic logic [31:0] rgb5a3(logic [15:0] v);
        if (v[15]) begin
            return {scale(v[14:10], 31), scale(v[9:5], 31), scale(v[4:0], 31), 8'hFF};
        end
        return {scale(v[11:8], 15), scale(v[7:4], 15), scale(v[3:0], 15),
                scale(v[14:12], 7)};
    endfunction

    function automatic int unsigned clamp_dim(logic [10:0] d);
        return (d > 11'd1024) ? 1024 : int'(d);
    endfunction

    // one of the four colours of a dxt1 sub-block
    function automatic logic [31:0] dxt_colour(logic [1:0] sel);
        logic [31:0] a, b, c;
        int unsigned p, q;
        a = rgb565(ep0);
        b = rgb565(ep1);
        c = '0;
        if (sel == 2'd0) return a;
        if (sel == 2'd1) return b;
        if (ep0 > ep1) begin
            for (int k = 0; k < 3; k++) begin
                p = a[31 - 8*k -: 8];
                q = b[31 - 8*k -: 8];
                c[31 - 8*k -: 8] = (sel == 2'd2) ? 8'((2*p + q) / 3) : 8'((p + 2*q) / 3);
            end
            c[7:0] = 8'hFF;
            return c;
        end
        if (sel == 2'd3) return '0;
        for (int k = 0; k < 3; k++) begin
            p = a[31 - 8*k -: 8];
            q = b[31 - 8*k -: 8];
            c[31 - 8*k -: 8] = 8'((p + q) / 2);
        end
        c[7:0] = 8'hFF;
        return c;
    endfunction

    // keep a pixel only when it lies inside the image
    task automatic put_pixel(int unsigned px, int unsigned py, logic [31:0] c);
        t_out_pix p;
        if (px >= clamp_dim(cur_width) || py >= clamp_dim(cur_height)) return;
        p.pix_x = px[9:0];
        p.pix_y = py[9:0];
        {p.red, p.green, p.blue, p.alpha} = c;
        p.last_of_run = 1'b0;
        run_pix.push_back(p);
    endtask

    // works out the pixels one accepted transfer gives
    task automatic decode_transfer(t_in_item it);
        int unsigned tw, th, tbytes, b, bx, by, x, y, i, k, sb, across, down;
        logic [7:0]  d;
        logic [15:0] v;
        logic [31:0] e;
        d = it.tex_byte;
        if (it.op == OP_PALETTE) begin
            if (cur_pal_fmt == PAL_IA8) e = {it.pal_value[15:8], it.pal_value[15:8],
                                            it.pal_value[15:8], it.pal_value[7:0]};
            else if (cur_pal_fmt == PAL_RGB565) e = rgb565(it.pal_value);
            else e = rgb5a3(it.pal_value);
            palette[it.pal_index] = e;
            return;
        end
        case (cur_fmt)
            FMT_I4, FMT_CI4, FMT_CMPR: begin tw = 8; th = 8; tbytes = 32; end
            FMT_I8, FMT_IA4, FMT_CI8, FMT_C14X2: begin tw = 8; th = 4; tbytes = 32; end
            FMT_IA8, FMT_RGB565, FMT_RGB5A3: begin tw = 4; th = 4; tbytes = 32; end
            FMT_RGBA8: begin tw = 4; th = 4; tbytes = 64; end
            default: return;  // unknown format: byte swallowed, walk untouched
        endcase
        if (it.first) begin
            walk_col = 0;
            walk_row = 0;
            walk_byte = 0;
        end
        if (walk_byte >= tbytes) walk_byte = tbytes - 1;
        b = walk_byte;
        bx = walk_col * tw;
        by = walk_row * th;
        run_pix.delete();
        case (cur_fmt)
            FMT_I4, FMT_CI4: begin
                x = bx + (b % 4) * 2;
                y = by + b / 4;
                if (cur_fmt == FMT_I4) begin
                    put_pixel(x, y, {{3{d[7:4], d[7:4]}}, 8'hFF});
                    put_pixel(x + 1, y, {{3{d[3:0], d[3:0]}}, 8'hFF});
                end else begin
                    put_pixel(x, y, palette[d[7:4]]);
                    put_pixel(x + 1, y, palette[d[3:0]]);
                end
            end
            FMT_I8, FMT_IA4, FMT_CI8, FMT_C14X2: begin
                x = bx + b % 8;
                y = by + b / 8;
                if (cur_fmt == FMT_I8) e = {d, d, d, 8'hFF};
                else if (cur_fmt == FMT_IA4) e = {{3{d[3:0], d[3:0]}}, d[7:4], d[7:4]};
                else e = palette[d];
                put_pixel(x, y, e);
            end
            FMT_IA8, FMT_RGB565, FMT_RGB5A3: begin
                if (b % 2 == 0) begin
                    held = d;
                end else begin
                    i = (b / 2) % 16;
                    v = {held, d};
                    if (cur_fmt == FMT_IA8) e = {d, d, d, held};
                    else if (cur_fmt == FMT_RGB565) e = rgb565(v);
                    else e = rgb5a3(v);
                    put_pixel(bx + i % 4, by + i / 4, e);
                end
            end
            FMT_RGBA8: begin
                if (b % 2 == 0) begin
                    held = d;
                end else begin
                    i = (b / 2) % 16;
                    if (b < 32) begin
                        ar_half[i] = {held, d};
                    end else begin
                        v = ar_half[i];
                        put_pixel(bx + i % 4, by + i / 4, {v[7:0], held, d, v[15:8]});
                    end
                end
            end
            default: begin  // cmpr
                k = b % 8;
                sb = (b / 8) % 4;
                if (k == 0 || k == 2) held = d;
                else if (k == 1) ep0 = {held, d};
                else if (k == 3) ep1 = {held, d};
                else begin
                    x = bx + (sb % 2) * 4;
                    y = by + (sb / 2) * 4 + (k - 4);
                    for (int j = 0; j < 4; j++) begin
                        put_pixel(x + j, y, dxt_colour(d[7 - 2*j -: 2]));
                    end
                end
            end
        endcase
        if (run_pix.size() > 0) run_pix[run_pix.size() - 1].last_of_run = 1'b1;
        foreach (run_pix[n]) pix_expected.push_back(run_pix[n]);
        across = (clamp_dim(cur_width) + tw - 1) / tw;
        down = (clamp_dim(cur_height) + th - 1) / th;
        if (across == 0) across = 1;
        if (down == 0) down = 1;
        walk_byte++;
        if (walk_byte >= tbytes) begin
            walk_byte = 0;
            walk_col++;
            if (walk_col >= across) begin
                walk_col = 0;
                walk_row++;
                if (walk_row >= down) walk_row = 0;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // driver: bursts of transfers from the pending queue with gaps
    // ---------------------------------------------------------------
    int burst_left = 8;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                decode_transfer(in_item);
                items_taken <= items_taken + 1;
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    in_item <= pending.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: stall pattern of its own plus one long hold-off
    // ---------------------------------------------------------------
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  stall_mode = 0;
    int  mode_left = 0;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!hold_done && items_taken >= 60) begin
            // block backs up and must stall its input
            hold_done <= 1'b1;
            hold_left <= 300;
            out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(4, 40);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // monitor: every pixel transfer against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_pix want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pix_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected pixel x=%0d y=%0d rgba=%h last=%b",
                             o_out_pix.pix_x, o_out_pix.pix_y,
                             {o_out_pix.red, o_out_pix.green, o_out_pix.blue,
                              o_out_pix.alpha}, o_out_pix.last_of_run);
                end
            end else begin
                want = pix_expected.pop_front();
                if (o_out_pix !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("pixel mismatch: want x=%0d y=%0d rgba=%h last=%b, got x=%0d y=%0d rgba=%h last=%b",
                                 want.pix_x, want.pix_y,
                                 {want.red, want.green, want.blue, want.alpha},
                                 want.last_of_run, o_out_pix.pix_x, o_out_pix.pix_y,
                                 {o_out_pix.red, o_out_pix.green, o_out_pix.blue,
                                  o_out_pix.alpha}, o_out_pix.last_of_run);
                    end
                end
            end
        end
    end

    // watchdog
    int cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tiled_texel_decoder verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic write_reg(logic [1:0] idx, logic [10:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_FORMAT:  cur_fmt = value[3:0];
            REG_WIDTH:   cur_width = value;
            REG_HEIGHT:  cur_height = value;
            default:     cur_pal_fmt = value[1:0];
        endcase
        cfg_valid <= 1'b0;
    endtask

    // wait until every transfer has gone and every pixel has come out
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending.size() > 0 || in_valid || pix_expected.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_mode(logic [3:0] fmt, logic [10:0] w, logic [10:0] h,
                            logic [1:0] pf);
        wait_idle();
        write_reg(REG_FORMAT, 11'(fmt));
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_PAL_FMT, 11'(pf));
    endtask

    task automatic push_byte(logic [7:0] d, logic first);
        t_in_item it;
        it = '0;
        it.op = OP_TEXEL;
        it.first = first;
        it.tex_byte = d;
        pending.push_back(it);
    endtask

    task automatic push_load(logic [7:0] idx, logic [15:0] value);
        t_in_item it;
        it = '0;
        it.op = OP_PALETTE;
        it.first = 1'b1;  // ignored on a palette load
        it.pal_index = idx;
        it.pal_value = value;
        pending.push_back(it);
    endtask

    function automatic logic [10:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return 11'd0;
            1: return 11'd1024;
            2: return 11'd2047;
            default: return 11'($urandom_range(1, 20));
        endcase
    endfunction

    initial begin
        int sent;
        int n;
        t_in_item it;
        logic [3:0] fmt;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: i4 8x8, extremes of the nibbles
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h0F, 1'b0);
        push_byte(8'hF0, 1'b0);

        // ci4 through an ia8 palette, an untouched entry still on the grey ramp
        set_mode(FMT_CI4, 11'd8, 11'd8, PAL_IA8);
        push_load(8'd1, 16'h80FF);
        push_byte(8'h1F, 1'b1);

        // ci8 through rgb565 and both rgb5a3 branches, palette format three too
        set_mode(FMT_CI8, 11'd3, 11'd1, PAL_RGB565);
        push_load(8'd255, 16'hFFFF);
        push_byte(8'hFF, 1'b1);
        set_mode(FMT_C14X2, 11'd1024, 11'd1024, PAL_RGB5A3);
        push_load(8'd4, 16'h8000);
        push_load(8'd5, 16'h7FFF);
        push_byte(8'h04, 1'b1);
        push_byte(8'h05, 1'b0);
        set_mode(FMT_CI8, 11'd2047, 11'd0, PAL_RGB5A3_ALT);
        push_load(8'd6, 16'h1234);
        push_byte(8'h06, 1'b1);

        // cmpr: three rows of one sub-block, all in the four-colour mode
        set_mode(FMT_CMPR, 11'd8, 11'd8, PAL_IA8);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hE4, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h1B, 1'b0);

        // random phases; rgba8 always starts its walk so no gb half reads stale data
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            fmt = 4'($urandom_range(0, 15));
            set_mode(fmt, pick_dim(), pick_dim(), 2'($urandom_range(0, 3)));
            n = (fmt == FMT_RGBA8) ? $urandom_range(32, 64) : $urandom_range(8, 24);
            for (int j = 0; j < n; j++) begin
                it.op = ($urandom_range(0, 7) == 0) ? OP_PALETTE : OP_TEXEL;
                if (j == 0 && fmt == FMT_RGBA8) it.op = OP_TEXEL;
                it.first = (j == 0 && fmt == FMT_RGBA8) || ($urandom_range(0, 19) == 0);
                it.tex_byte = 8'($urandom);
                it.pal_index = 8'($urandom);
                it.pal_value = 16'($urandom);
                pending.push_back(it);
            end
            sent += n;
        end

        wait_idle();
        if (mismatches == 0 && pix_expected.size() == 0) begin
            $display("tiled_texel_decoder verification clean");
        end else begin
            $display("tiled_texel_decoder verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/ttd_pkg.sv
design/ttd_ram.sv
design/ttd_front.sv
design/ttd_fifo.sv
design/ttd_back.sv
design/tiled_texel_decoder.sv
tb/tb_top.sv
